// ===== hw/rtl/sit_pkg.sv =====
// shared constants and types for the segment intersection test
// no dependencies
`default_nettype none

package sit_pkg;

    localparam int COORD_BITS_DEFAULT = 16;
    localparam int TOL_BITS           = 32;

    // how the two carrying lines relate
    typedef enum logic [1:0] {
        REL_CROSS     = 2'd0,
        REL_OUTSIDE   = 2'd1,
        REL_PARALLEL  = 2'd2,
        REL_COLLINEAR = 2'd3
    } relation_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sit_pair_if.sv =====
// input channel: one pair of segments per transfer
// depends on sit_pkg for the default coordinate width
`default_nettype none

interface sit_pair_if
    import sit_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] first_start_x;
    logic signed [COORD_BITS-1:0] first_start_y;
    logic signed [COORD_BITS-1:0] first_end_x;
    logic signed [COORD_BITS-1:0] first_end_y;
    logic signed [COORD_BITS-1:0] second_start_x;
    logic signed [COORD_BITS-1:0] second_start_y;
    logic signed [COORD_BITS-1:0] second_end_x;
    logic signed [COORD_BITS-1:0] second_end_y;

    modport source (
        output valid, first_start_x, first_start_y, first_end_x, first_end_y,
               second_start_x, second_start_y, second_end_x, second_end_y,
        input  ready
    );

    modport sink (
        input  valid, first_start_x, first_start_y, first_end_x, first_end_y,
               second_start_x, second_start_y, second_end_x, second_end_y,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/sit_result_if.sv =====
// result channel: intersection flag and relation code per transfer
// no dependencies
`default_nettype none

interface sit_result_if;
    logic       valid;
    logic       ready;
    logic       intersects;
    logic [1:0] relation;

    modport source (
        output valid, intersects, relation,
        input  ready
    );

    modport sink (
        input  valid, intersects, relation,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/sit_cfg_if.sv =====
// configuration write channel for the collinear tolerance register
// depends on sit_pkg for the register width
`default_nettype none

interface sit_cfg_if
    import sit_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [TOL_BITS-1:0] collinear_tolerance;

    modport source (
        output valid, collinear_tolerance,
        input  ready
    );

    modport sink (
        input  valid, collinear_tolerance,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/sit_point_test.sv =====
// pipelined point-on-segment test: products, sums, then tolerance and bounds
// depends on sit_pkg; takes registered differences, result registered after products, sums and compare
`default_nettype none

module sit_point_test
    import sit_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)(
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic signed [COORD_BITS:0] dir_x,
    input  wire logic signed [COORD_BITS:0] dir_y,
    input  wire logic signed [COORD_BITS:0] ofs_x,
    input  wire logic signed [COORD_BITS:0] ofs_y,
    input  wire logic [TOL_BITS-1:0]        tol,
    output logic                            on_reg
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int CW = ((PW > TOL_BITS) ? PW : TOL_BITS) + 1;

    logic signed [PW-1:0] cross_a_reg, cross_b_reg;
    logic signed [PW-1:0] dot_a_reg, dot_b_reg;
    logic signed [PW-1:0] len_a_reg, len_b_reg;
    logic                 pt_s2_reg, qz_s2_reg;

    logic signed [PW-1:0] cross_reg, dot_reg, len_reg;
    logic                 pt_s3_reg, qz_s3_reg;

    logic signed [CW-1:0] cross_ext, tol_ext;
    logic                 on_next;

    // products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cross_a_reg <= PW'(ofs_y) * PW'(dir_x);
            cross_b_reg <= PW'(ofs_x) * PW'(dir_y);
            dot_a_reg   <= PW'(ofs_x) * PW'(dir_x);
            dot_b_reg   <= PW'(ofs_y) * PW'(dir_y);
            len_a_reg   <= PW'(dir_x) * PW'(dir_x);
            len_b_reg   <= PW'(dir_y) * PW'(dir_y);
            pt_s2_reg   <= (dir_x == '0) && (dir_y == '0);
            qz_s2_reg   <= (ofs_x == '0) && (ofs_y == '0);
        end
    end

    // sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cross_reg <= cross_a_reg - cross_b_reg;
            dot_reg   <= dot_a_reg + dot_b_reg;
            len_reg   <= len_a_reg + len_b_reg;
            pt_s3_reg <= pt_s2_reg;
            qz_s3_reg <= qz_s2_reg;
        end
    end

    // |cross| <= tol written as two compares, against tol and against -tol
    assign cross_ext = CW'(cross_reg);
    assign tol_ext   = $signed({{(CW - TOL_BITS){1'b0}}, tol});

    always_comb
    begin
        if (pt_s3_reg)
            on_next = qz_s3_reg;
        else
            on_next = (cross_ext <= tol_ext) && (cross_ext >= -tol_ext)
                   && !dot_reg[PW-1] && (dot_reg <= len_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            on_reg <= on_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/segment_intersection_test.sv =====
// Segment intersection test: first segment A->B, second C->D, signed
// coordinates of COORD_BITS bits. One pair is taken per clock while the
// output is not stalled; the result passes the difference, product, sum,
// compare and output stages, the first loaded by the transfer itself, every
// multiplier fully pipelined. The whole pipeline advances together; ready
// drops only while a finished result is held on the output and not taken.
// The tolerance register is written over the cfg channel, which is always
// ready; write it only while no pair is in flight. Relation codes: crossing
// inside both segments, crossing outside, parallel apart, collinear
// (resolved by testing all four endpoints).
// depends on sit_pkg, the three channel interfaces and sit_point_test
`default_nettype none

module segment_intersection_test
    import sit_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)(
    input  wire logic   clk,
    input  wire logic   rst_n,
    sit_pair_if.sink    pair,
    sit_result_if.source result,
    sit_cfg_if.sink     cfg
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    // pipeline control: every stage moves when the output can move
    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;

    logic [TOL_BITS-1:0] tol_reg;

    // stage 1: coordinate differences
    logic signed [DW-1:0] bax_reg, bay_reg;   // B - A
    logic signed [DW-1:0] dcx_reg, dcy_reg;   // D - C
    logic signed [DW-1:0] acx_reg, acy_reg;   // A - C
    logic signed [DW-1:0] cax_reg, cay_reg;   // C - A
    logic signed [DW-1:0] dax_reg, day_reg;   // D - A
    logic signed [DW-1:0] bcx_reg, bcy_reg;   // B - C

    // stage 2: products for den and the two numerators
    logic signed [PW-1:0] den_a_reg, den_b_reg;
    logic signed [PW-1:0] nr_a_reg, nr_b_reg;
    logic signed [PW-1:0] ns_a_reg, ns_b_reg;

    // stage 3: den, num_r, num_s
    logic signed [PW-1:0] den_reg, num_r_reg, num_s_reg;

    // stage 4: sign and range flags
    logic den_zero_reg, nr_zero_reg, r_in_reg, s_in_reg;
    logic r_in_next, s_in_next;

    // endpoint tests, aligned with stage 4
    logic c_on_ab, d_on_ab, a_on_cd, b_on_cd;

    // stage 5: output register
    logic      intersects_reg;
    relation_t relation_reg;
    logic      hit_next;
    relation_t rel_next;

    assign en         = !out_valid_reg || result.ready;
    assign pair.ready = en;
    assign cfg.ready  = 1'b1;

    // tolerance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= '0;
        else if (cfg.valid)
            tol_reg <= cfg.collinear_tolerance;
    end

    // valid bits travel beside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= pair.valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    // stage 1: differences, sign extended by one bit so they cannot wrap
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bax_reg <= DW'(pair.first_end_x) - DW'(pair.first_start_x);
            bay_reg <= DW'(pair.first_end_y) - DW'(pair.first_start_y);
            dcx_reg <= DW'(pair.second_end_x) - DW'(pair.second_start_x);
            dcy_reg <= DW'(pair.second_end_y) - DW'(pair.second_start_y);
            acx_reg <= DW'(pair.first_start_x) - DW'(pair.second_start_x);
            acy_reg <= DW'(pair.first_start_y) - DW'(pair.second_start_y);
            cax_reg <= DW'(pair.second_start_x) - DW'(pair.first_start_x);
            cay_reg <= DW'(pair.second_start_y) - DW'(pair.first_start_y);
            dax_reg <= DW'(pair.second_end_x) - DW'(pair.first_start_x);
            day_reg <= DW'(pair.second_end_y) - DW'(pair.first_start_y);
            bcx_reg <= DW'(pair.first_end_x) - DW'(pair.second_start_x);
            bcy_reg <= DW'(pair.first_end_y) - DW'(pair.second_start_y);
        end
    end

    // stage 2: six products for the line test
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_a_reg <= PW'(bax_reg) * PW'(dcy_reg);
            den_b_reg <= PW'(bay_reg) * PW'(dcx_reg);
            nr_a_reg  <= PW'(acy_reg) * PW'(dcx_reg);
            nr_b_reg  <= PW'(acx_reg) * PW'(dcy_reg);
            ns_a_reg  <= PW'(acy_reg) * PW'(bax_reg);
            ns_b_reg  <= PW'(acx_reg) * PW'(bay_reg);
        end
    end

    // stage 3: cross products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg   <= den_a_reg - den_b_reg;
            num_r_reg <= nr_a_reg - nr_b_reg;
            num_s_reg <= ns_a_reg - ns_b_reg;
        end
    end

    // stage 4: num/den in [0,1] by sign, with den's sign folded in
    always_comb
    begin
        if (den_reg[PW-1])
        begin
            r_in_next = (num_r_reg <= 0) && (num_r_reg >= den_reg);
            s_in_next = (num_s_reg <= 0) && (num_s_reg >= den_reg);
        end
        else
        begin
            r_in_next = (num_r_reg >= 0) && (num_r_reg <= den_reg);
            s_in_next = (num_s_reg >= 0) && (num_s_reg <= den_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_zero_reg <= (den_reg == '0);
            nr_zero_reg  <= (num_r_reg == '0);
            r_in_reg     <= r_in_next;
            s_in_reg     <= s_in_next;
        end
    end

    // endpoint tests for the collinear case, both segments' ends checked
    sit_point_test #(.COORD_BITS(COORD_BITS)) u_c_on_ab (
        .clk(clk), .en(en),
        .dir_x(bax_reg), .dir_y(bay_reg), .ofs_x(cax_reg), .ofs_y(cay_reg),
        .tol(tol_reg), .on_reg(c_on_ab)
    );

    sit_point_test #(.COORD_BITS(COORD_BITS)) u_d_on_ab (
        .clk(clk), .en(en),
        .dir_x(bax_reg), .dir_y(bay_reg), .ofs_x(dax_reg), .ofs_y(day_reg),
        .tol(tol_reg), .on_reg(d_on_ab)
    );

    sit_point_test #(.COORD_BITS(COORD_BITS)) u_a_on_cd (
        .clk(clk), .en(en),
        .dir_x(dcx_reg), .dir_y(dcy_reg), .ofs_x(acx_reg), .ofs_y(acy_reg),
        .tol(tol_reg), .on_reg(a_on_cd)
    );

    sit_point_test #(.COORD_BITS(COORD_BITS)) u_b_on_cd (
        .clk(clk), .en(en),
        .dir_x(dcx_reg), .dir_y(dcy_reg), .ofs_x(bcx_reg), .ofs_y(bcy_reg),
        .tol(tol_reg), .on_reg(b_on_cd)
    );

    // stage 5: classify
    always_comb
    begin
        if (den_zero_reg)
        begin
            if (nr_zero_reg)
            begin
                rel_next = REL_COLLINEAR;
                hit_next = c_on_ab || d_on_ab || a_on_cd || b_on_cd;
            end
            else
            begin
                rel_next = REL_PARALLEL;
                hit_next = 1'b0;
            end
        end
        else if (r_in_reg && s_in_reg)
        begin
            rel_next = REL_CROSS;
            hit_next = 1'b1;
        end
        else
        begin
            rel_next = REL_OUTSIDE;
            hit_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            intersects_reg <= hit_next;
            relation_reg   <= rel_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.intersects = intersects_reg;
    assign result.relation   = relation_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/sit_checker.sv =====
// port-level assertions for segment_intersection_test, attached by bind
// depends on sit_pkg for the relation codes
`default_nettype none

module sit_checker
    import sit_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       pair_ready,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic       res_intersects,
    input wire logic [1:0] res_relation
);

    // a held result keeps its value until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_intersects)
                                    && $stable(res_relation))
    else $error("result changed while stalled");

    // only an output stall may hold off new pairs
    assert property (@(posedge clk) disable iff (!rst_n)
        !pair_ready |-> res_valid && !res_ready)
    else $error("input blocked without an output stall");

    // a hit is either a proper crossing or a collinear overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_intersects |->
            (res_relation == REL_CROSS) || (res_relation == REL_COLLINEAR))
    else $error("hit reported with a non-touching relation");

    // a crossing inside both segments is always a hit
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_relation == REL_CROSS) |-> res_intersects)
    else $error("crossing reported without a hit");

endmodule

bind segment_intersection_test sit_checker u_sit_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .pair_ready    (pair.ready),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .res_intersects(result.intersects),
    .res_relation  (result.relation)
);

`default_nettype wire
